// File: src/xor_delta_number_encoder_top_assert.svh
// Assertion macros for the XOR delta number encoder.
// Expects signals named clk and rst in the including module.
`ifndef XOR_DELTA_NUMBER_ENCODER_TOP_ASSERT_SVH
`define XOR_DELTA_NUMBER_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XDNE_ASSERT_IMPLY(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("xdne assertion failed");

// Next-cycle implication, disabled during reset.
`define XDNE_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("xdne assertion failed");

`endif

// File: src/xdne_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the XOR delta number encoder.
// No dependencies; used by the coder, the packer and the top level.
package xdne_pkg;

  localparam int WORD_W       = 32;
  localparam int LZC_W        = 5;
  localparam int CODE_W       = WORD_W + LZC_W + 2;
  localparam int LEN_W        = 6;
  localparam int POS_W        = 16;
  localparam int WORD_INDEX_W = 10;
  localparam int BUFFER_WORDS = 1024;

  // Largest usable capacity in bits, one bit wider than the capacity register.
  localparam logic [POS_W:0] CAP_MAX = (POS_W + 1)'(BUFFER_WORDS * WORD_W);

  localparam logic [POS_W-1:0] CAPACITY_RESET = 16'd32768;

  localparam logic OP_ENCODE     = 1'b0;
  localparam logic OP_NEW_BUFFER = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic [LZC_W-1:0]  lzc;
  } code_t;

  typedef struct packed {
    logic                    accepted;
    logic [WORD_W-1:0]       first_word;
    logic                    first_word_valid;
    logic [WORD_W-1:0]       second_word;
    logic                    second_word_valid;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [POS_W-1:0]        entry_count;
    logic [POS_W-1:0]        bit_count;
  } result_t;

endpackage

// File: src/xdne_entry_coder.sv
`timescale 1ns / 1ps
// Builds the bit code of one entry: raw, repeat flag, or XOR delta.
// Depends on xdne_pkg.
module xdne_entry_coder (
  input  logic                                first_entry,
  input  logic [xdne_pkg::WORD_W-1:0]         number,
  input  logic [xdne_pkg::WORD_W-1:0]         previous_number,
  input  logic [xdne_pkg::LZC_W-1:0]          previous_zero_count,
  output xdne_pkg::code_t                     code
);

  function automatic logic [xdne_pkg::LZC_W-1:0] lead_zeros(
    input logic [xdne_pkg::WORD_W-1:0] x
  );
    logic [xdne_pkg::LZC_W-1:0] n;
    n = '0;
    // highest set bit wins; an all-zero word is never coded this way
    for (int i = 0; i < xdne_pkg::WORD_W; i++) begin
      if (x[i]) n = xdne_pkg::LZC_W'(xdne_pkg::WORD_W - 1 - i);
    end
    return n;
  endfunction

  logic [xdne_pkg::WORD_W-1:0] delta;
  logic [xdne_pkg::LZC_W-1:0]  lzc;
  logic                        same;

  assign delta = previous_number ^ number;
  assign lzc   = lead_zeros(delta);
  assign same  = (lzc == previous_zero_count);

  always_comb begin
    code.lzc = lzc;
    if (first_entry) begin
      code.bits = {{(xdne_pkg::CODE_W - xdne_pkg::WORD_W){1'b0}}, number};
      code.len  = xdne_pkg::LEN_W'(xdne_pkg::WORD_W);
    end else if (delta == '0) begin
      code.bits = xdne_pkg::CODE_W'(1);
      code.len  = xdne_pkg::LEN_W'(1);
    end else if (same) begin
      // flags 0,1 then the significant delta bits
      code.bits = {{xdne_pkg::LZC_W{1'b0}}, delta, 1'b1, 1'b0};
      code.len  = xdne_pkg::LEN_W'(2 + xdne_pkg::WORD_W) - xdne_pkg::LEN_W'(lzc);
    end else begin
      // flags 0,0, new count, then the significant delta bits
      code.bits = {delta, lzc, 1'b0, 1'b0};
      code.len  = xdne_pkg::LEN_W'(2 + xdne_pkg::LZC_W + xdne_pkg::WORD_W)
                  - xdne_pkg::LEN_W'(lzc);
    end
  end

endmodule

// File: src/xdne_bit_packer.sv
`timescale 1ns / 1ps
// Stream state and word packing: places one entry code into the bit stream.
// Depends on xdne_pkg and xdne_entry_coder.
module xdne_bit_packer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              opcode,
  input  logic [xdne_pkg::WORD_W-1:0]       number,
  input  logic [xdne_pkg::POS_W-1:0]        capacity_bits,
  output xdne_pkg::result_t                 result
);

  localparam int WIN_W = 3 * xdne_pkg::WORD_W;
  localparam int OFF_W = $clog2(xdne_pkg::WORD_W);
  localparam int END_W = OFF_W + 2;

  logic [xdne_pkg::WORD_W-1:0] previous_number;
  logic [xdne_pkg::LZC_W-1:0]  previous_zero_count;
  logic [xdne_pkg::POS_W-1:0]  used_bits;
  logic [xdne_pkg::POS_W-1:0]  stored_entries;
  logic [xdne_pkg::WORD_W-1:0] partial_word;

  logic [xdne_pkg::WORD_W-1:0] previous_number_next;
  logic [xdne_pkg::LZC_W-1:0]  previous_zero_count_next;
  logic [xdne_pkg::POS_W-1:0]  used_bits_next;
  logic [xdne_pkg::POS_W-1:0]  stored_entries_next;
  logic [xdne_pkg::WORD_W-1:0] partial_word_next;

  xdne_pkg::code_t             code;
  logic [OFF_W-1:0]            offset;
  logic [END_W-1:0]            end_pos;
  logic [xdne_pkg::POS_W:0]    cap_eff;
  logic                        fits;
  logic [WIN_W-1:0]            window;
  logic                        done0;
  logic                        done1;

  xdne_entry_coder u_coder (
    .first_entry         (stored_entries == '0),
    .number              (number),
    .previous_number     (previous_number),
    .previous_zero_count (previous_zero_count),
    .code                (code)
  );

  assign offset  = used_bits[OFF_W-1:0];
  assign end_pos = END_W'(offset) + END_W'(code.len);
  assign cap_eff = ({1'b0, capacity_bits} > xdne_pkg::CAP_MAX) ?
                   xdne_pkg::CAP_MAX : {1'b0, capacity_bits};
  assign fits    = ({1'b0, used_bits} + (xdne_pkg::POS_W + 1)'(code.len)) < cap_eff;
  assign window  = ({{(WIN_W - xdne_pkg::CODE_W){1'b0}}, code.bits} << offset)
                   | {{(WIN_W - xdne_pkg::WORD_W){1'b0}}, partial_word};
  assign done0   = end_pos >= END_W'(xdne_pkg::WORD_W);
  assign done1   = end_pos >= END_W'(2 * xdne_pkg::WORD_W);

  always_comb begin
    previous_number_next     = previous_number;
    previous_zero_count_next = previous_zero_count;
    used_bits_next           = used_bits;
    stored_entries_next      = stored_entries;
    partial_word_next        = partial_word;
    result                   = '0;
    result.entry_count       = stored_entries;
    result.bit_count         = used_bits;
    if (opcode == xdne_pkg::OP_NEW_BUFFER) begin
      // flush a partly filled word, then clear the stream
      result.first_word_valid  = (offset != '0);
      result.first_word        = (offset != '0) ? partial_word : '0;
      result.word_index        = (offset != '0) ?
                                 used_bits[xdne_pkg::WORD_INDEX_W+OFF_W-1:OFF_W] : '0;
      result.entry_count       = '0;
      result.bit_count         = '0;
      previous_number_next     = '0;
      previous_zero_count_next = '0;
      used_bits_next           = '0;
      stored_entries_next      = '0;
      partial_word_next        = '0;
    end else if (fits) begin
      result.accepted          = 1'b1;
      result.first_word_valid  = done0;
      result.first_word        = done0 ? window[xdne_pkg::WORD_W-1:0] : '0;
      result.second_word_valid = done1;
      result.second_word       = done1 ? window[2*xdne_pkg::WORD_W-1:xdne_pkg::WORD_W] : '0;
      result.word_index        = done0 ?
                                 used_bits[xdne_pkg::WORD_INDEX_W+OFF_W-1:OFF_W] : '0;
      used_bits_next           = used_bits + xdne_pkg::POS_W'(code.len);
      stored_entries_next      = stored_entries + xdne_pkg::POS_W'(1);
      result.entry_count       = stored_entries_next;
      result.bit_count         = used_bits_next;
      if (stored_entries == '0 || number != previous_number) begin
        previous_number_next = number;
        if (stored_entries != '0) previous_zero_count_next = code.lzc;
      end
      if (done1) begin
        partial_word_next = window[WIN_W-1:2*xdne_pkg::WORD_W];
      end else if (done0) begin
        partial_word_next = window[2*xdne_pkg::WORD_W-1:xdne_pkg::WORD_W];
      end else begin
        partial_word_next = window[xdne_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_number     <= '0;
      previous_zero_count <= '0;
      used_bits           <= '0;
      stored_entries      <= '0;
      partial_word        <= '0;
    end else if (step) begin
      previous_number     <= previous_number_next;
      previous_zero_count <= previous_zero_count_next;
      used_bits           <= used_bits_next;
      stored_entries      <= stored_entries_next;
      partial_word        <= partial_word_next;
    end
  end

endmodule

// File: src/xor_delta_number_encoder_top.sv
`timescale 1ns / 1ps
// Top level of the XOR delta number encoder: input register, packer, result register.
// Depends on xdne_pkg, xdne_bit_packer and xor_delta_number_encoder_top_assert.svh.
//
// Usage:
//   item channel   : item_valid / item_stall, payload opcode and number. A beat
//                    moves at a clock edge with item_valid high and item_stall low.
//                    opcode encode appends number to the buffer's bit stream;
//                    opcode new buffer flushes a partial word and clears the stream.
//   result channel : result_valid / result_stall, one result beat per item,
//                    carrying up to two finished 32-bit words at word_index and
//                    word_index + 1, the accepted flag and the running counts.
//   config channel : cfg_valid / cfg_ready / cfg_data writes capacity_bits; the
//                    port is always ready. Write it only while the block is idle.
// Path: the beat loads the input register, then the packer result loads the result register.
// Throughput: one item per cycle while result_stall is low. Leading-zero count, code build
//   and a 96-bit barrel shift into the word window all sit between the input register
//   and the result register; the stream state updates in the same cycle.
// Reset (rst, synchronous): empty both registers, clear the stream, capacity 32768 bits.
// Stall: while result_stall holds a result, one more item is taken into the
//   input register; item_stall then rises until the result beat moves.

`include "xor_delta_number_encoder_top_assert.svh"

module xor_delta_number_encoder_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   opcode,
  input  logic [xdne_pkg::WORD_W-1:0]            number,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   accepted,
  output logic [xdne_pkg::WORD_W-1:0]            first_word,
  output logic                                   first_word_valid,
  output logic [xdne_pkg::WORD_W-1:0]            second_word,
  output logic                                   second_word_valid,
  output logic [xdne_pkg::WORD_INDEX_W-1:0]      word_index,
  output logic [xdne_pkg::POS_W-1:0]             entry_count,
  output logic [xdne_pkg::POS_W-1:0]             bit_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [xdne_pkg::POS_W-1:0]             cfg_data
);

  logic                         stage_valid;
  logic                         stage_opcode;
  logic [xdne_pkg::WORD_W-1:0]  stage_number;
  logic [xdne_pkg::POS_W-1:0]   capacity_bits;
  xdne_pkg::result_t            packed_result;
  xdne_pkg::result_t            result;
  logic                         load_result;
  logic                         step;
  logic                         take_item;

  // The result register can load when empty or when its beat moves now.
  assign load_result = !result_valid || !result_stall;
  assign step        = stage_valid && load_result;
  assign item_stall  = stage_valid && !load_result;
  assign take_item   = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  // Capacity register: the user must write it only while idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bits <= xdne_pkg::CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_bits <= cfg_data;
    end
  end

  // Input register: hold the item until the packer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take_item) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      stage_opcode <= opcode;
      stage_number <= number;
    end
  end

  xdne_bit_packer u_packer (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .opcode        (stage_opcode),
    .number        (stage_number),
    .capacity_bits (capacity_bits),
    .result        (packed_result)
  );

  // Result register: advance on load, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= packed_result;
    end
  end

  assign accepted          = result.accepted;
  assign first_word        = result.first_word;
  assign first_word_valid  = result.first_word_valid;
  assign second_word       = result.second_word;
  assign second_word_valid = result.second_word_valid;
  assign word_index        = result.word_index;
  assign entry_count       = result.entry_count;
  assign bit_count         = result.bit_count;

  // A second finished word never comes without the first.
  `XDNE_ASSERT_IMPLY(a_second_needs_first, result_valid && second_word_valid, first_word_valid)
  // The word index is only set alongside a word.
  `XDNE_ASSERT_IMPLY(a_index_needs_word, result_valid && (word_index != '0), first_word_valid)
  // An encoded entry always leaves a nonempty buffer behind.
  `XDNE_ASSERT_IMPLY(a_accept_counts, result_valid && accepted,
                     (entry_count != '0) && (bit_count != '0))
  // Input stalls only with a held item and a blocked result.
  `XDNE_ASSERT_IMPLY(a_stall_cause, item_stall, stage_valid && result_valid && result_stall)
  // A taken item is in the input register on the next cycle.
  `XDNE_ASSERT_NEXT(a_item_lands, take_item, stage_valid)

endmodule
